@@ design/rkla_pkg.sv @@
package rkla_pkg;

    // Fixed field widths
    localparam int CMD_W   = 3;
    localparam int CPU_W   = 5;
    localparam int DEPTH_W = 8;
    localparam int CPUS    = 32;

    // Configuration port
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;
    localparam int ONLINE_W = 6;
    localparam logic [ONLINE_W-1:0] MIN_ONLINE = ONLINE_W'(2);
    localparam logic [ONLINE_W-1:0] ONLINE_RST = ONLINE_W'(1);
    localparam logic [DEPTH_W-1:0]  DEPTH_MAX  = '1;

    // Register indexes (word address = paddr[APB_AW-1:2])
    localparam logic [APB_AW-3:0] REG_SCHED  = 1'b0;
    localparam logic [APB_AW-3:0] REG_ONLINE = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENTER   = 3'd0,
        CMD_TRY     = 3'd1,
        CMD_REL_ONE = 3'd2,
        CMD_REL_ALL = 3'd3,
        CMD_QUERY   = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [CPU_W-1:0] cpu;
    } req_t;

    typedef struct packed {
        logic               granted;
        logic               held;
        logic [DEPTH_W-1:0] depth;
    } res_t;

endpackage

@@ design/recursive_kernel_lock_arbiter.sv @@
// Recursive kernel lock arbiter: one lock shared by the CPUs of a cluster.
//
// Request channel: in_valid/in_ready carry command and requester. Commands
// are enter, timer try-enter, release one level, release all, and query.
// Response channel: out_valid/out_ready carry granted, held_by_requester and
// nest_depth, one response per request, in request order.
// Configuration: APB write of scheduler_running (0x0) and online_cpus (0x4);
// the lock only arbitrates when the scheduler runs and two or more CPUs are
// online. Write configuration only while no request is in flight.
//
// The request transfer loads the request register, and the response register
// takes the result once its slot is free or draining. One request is taken
// every cycle while out_ready stays high: a request register feeds one level
// of compare/update logic into the response register.
// When the receiver stalls, the response holds, the request register fills,
// and in_ready drops until out_ready returns.
// Reset frees the lock, clears the nesting depth and the boot-CPU waiting
// flag, clears scheduler_running and sets online_cpus to one.
module recursive_kernel_lock_arbiter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rkla_pkg::CMD_W-1:0]          command,
    input  logic [rkla_pkg::CPU_W-1:0]          requester,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                granted,
    output logic                                held_by_requester,
    output logic [rkla_pkg::DEPTH_W-1:0]        nest_depth,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rkla_pkg::APB_AW-1:0]         paddr,
    input  logic [rkla_pkg::APB_DW-1:0]         pwdata,
    output logic [rkla_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import rkla_pkg::*;

    logic  req_valid_reg;
    logic  req_valid_next;
    req_t  req_reg;
    logic  rsp_valid_reg;
    logic  rsp_valid_next;
    res_t  rsp_reg;
    res_t  core_res;
    logic  gate_open;
    logic  in_xfer;
    logic  advance;

    assign pready = 1'b1;

    rkla_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .gate_open (gate_open)
    );

    // Advance the request into the response register whenever that slot is
    // free or being drained this cycle.
    assign advance  = req_valid_reg && (!rsp_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    rkla_lock_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .gate_open (gate_open),
        .req       (req_reg),
        .res       (core_res)
    );

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_xfer)
            req_valid_next = 1'b1;
        else if (advance)
            req_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (advance)
            rsp_valid_next = 1'b1;
        else if (out_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg.cmd <= command;
            req_reg.cpu <= requester;
        end
        if (advance)
            rsp_reg <= core_res;
    end

    assign out_valid         = rsp_valid_reg;
    assign granted           = rsp_reg.granted;
    assign held_by_requester = rsp_reg.held;
    assign nest_depth        = rsp_reg.depth;

endmodule

@@ design/rkla_cfg_regs.sv @@
module rkla_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rkla_pkg::APB_AW-1:0]  paddr,
    input  logic [rkla_pkg::APB_DW-1:0]  pwdata,
    output logic [rkla_pkg::APB_DW-1:0]  prdata,
    output logic                         gate_open
);
    import rkla_pkg::*;

    logic                sched_reg;
    logic                sched_next;
    logic [ONLINE_W-1:0] online_reg;
    logic [ONLINE_W-1:0] online_next;
    logic                wr_en;
    logic [APB_AW-3:0]   word_addr;

    assign wr_en     = psel && penable && pwrite;
    assign word_addr = paddr[APB_AW-1:2];

    always_comb
    begin
        sched_next  = sched_reg;
        online_next = online_reg;
        if (wr_en)
        begin
            case (word_addr)
                REG_SCHED:  sched_next  = pwdata[0];
                REG_ONLINE: online_next = pwdata[ONLINE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_reg  <= 1'b0;
            online_reg <= ONLINE_RST;
        end
        else
        begin
            sched_reg  <= sched_next;
            online_reg <= online_next;
        end
    end

    always_comb
    begin
        case (word_addr)
            REG_SCHED:  prdata = {{(APB_DW-1){1'b0}}, sched_reg};
            REG_ONLINE: prdata = {{(APB_DW-ONLINE_W){1'b0}}, online_reg};
            default:    prdata = '0;
        endcase
    end

    assign gate_open = sched_reg && (online_reg >= MIN_ONLINE);

endmodule

@@ design/rkla_lock_core.sv @@
module rkla_lock_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  logic           gate_open,
    input  rkla_pkg::req_t req,
    output rkla_pkg::res_t res
);
    import rkla_pkg::*;

    logic               owner_valid_reg;
    logic               owner_valid_next;
    logic [CPU_W-1:0]   owner_cpu_reg;
    logic [CPU_W-1:0]   owner_cpu_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic               waiting_reg;
    logic               waiting_next;

    logic [CPU_W-1:0]   cpu;
    logic               is_boot;
    logic               is_owner;
    logic               timer;
    logic               granted;

    // Out-of-range requesters map onto the boot CPU
    assign cpu      = (32'(req.cpu) < CPUS) ? req.cpu : '0;
    assign is_boot  = (cpu == '0);
    assign is_owner = owner_valid_reg && (owner_cpu_reg == cpu);
    assign timer    = (req.cmd == CMD_TRY);

    always_comb
    begin
        owner_valid_next = owner_valid_reg;
        owner_cpu_next   = owner_cpu_reg;
        depth_next       = depth_reg;
        waiting_next     = waiting_reg;
        granted          = 1'b0;
        case (req.cmd)
            CMD_ENTER, CMD_TRY:
            begin
                if (!gate_open)
                    granted = 1'b1;
                else if (is_owner)
                begin
                    granted = 1'b1;
                    if (depth_reg != DEPTH_MAX)
                        depth_next = depth_reg + 1'b1;
                end
                else if (timer && !is_boot && waiting_reg)
                    granted = 1'b0;
                else if (!owner_valid_reg)
                begin
                    granted          = 1'b1;
                    owner_valid_next = 1'b1;
                    owner_cpu_next   = cpu;
                    depth_next       = DEPTH_W'(1);
                    if (is_boot)
                        waiting_next = 1'b0;
                end
                else if (!timer && is_boot)
                    waiting_next = 1'b1;
            end
            CMD_REL_ONE:
            begin
                if (is_owner && depth_reg != '0)
                begin
                    depth_next = depth_reg - 1'b1;
                    if (depth_reg == DEPTH_W'(1))
                    begin
                        owner_valid_next = 1'b0;
                        owner_cpu_next   = '0;
                    end
                end
            end
            CMD_REL_ALL:
            begin
                if (gate_open && is_owner)
                begin
                    owner_valid_next = 1'b0;
                    owner_cpu_next   = '0;
                    depth_next       = '0;
                end
            end
            default: ;
        endcase
    end

    assign res.granted = granted;
    assign res.held    = owner_valid_next && (owner_cpu_next == cpu) && (depth_next != '0);
    assign res.depth   = depth_next;

    // Commit the update only when the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_valid_reg <= 1'b0;
            owner_cpu_reg   <= '0;
            depth_reg       <= '0;
            waiting_reg     <= 1'b0;
        end
        else if (fire)
        begin
            owner_valid_reg <= owner_valid_next;
            owner_cpu_reg   <= owner_cpu_next;
            depth_reg       <= depth_next;
            waiting_reg     <= waiting_next;
        end
    end

endmodule

@@ design/rkla_checker.sv @@
module rkla_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                granted,
    input  logic                                held_by_requester,
    input  logic [rkla_pkg::DEPTH_W-1:0]        nest_depth,
    input  logic [rkla_pkg::APB_AW-1:0]         paddr,
    input  logic [rkla_pkg::APB_DW-1:0]         prdata
);
    import rkla_pkg::*;

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(granted)
            && $stable(held_by_requester) && $stable(nest_depth))
        else $error("response changed while stalled");

    // Ownership always comes with a nonzero depth
    a_held_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && held_by_requester |-> nest_depth != '0)
        else $error("held with zero depth");

    // With the response slot empty the request side never backs up
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request stalled with empty response slot");

    // scheduler_running reads back as a single bit
    a_sched_rd: assert property (@(posedge clk) disable iff (!rst_n)
        paddr[APB_AW-1:2] == REG_SCHED |-> prdata[APB_DW-1:1] == '0)
        else $error("scheduler_running readback has stray bits");

endmodule

bind recursive_kernel_lock_arbiter rkla_checker u_rkla_checker (.*);

@@ sim/tb.sv @@
module tb;

    import rkla_pkg::*;

    // Byte addresses of the two configuration registers (one 32-bit word each)
    localparam logic [APB_AW-1:0] ADDR_SCHED  = {REG_SCHED, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_ONLINE = {REG_ONLINE, 2'b00};

    // Command codes past the defined set; the lock must treat them as a query
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_QUERY + 1'b1;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;

    localparam logic [CPU_W-1:0] BOOT_CPU = '0;

    // Configuration plan of the random phases, one entry per phase
    localparam logic [7:0]           SCHED_PLAN  = 8'b1101_1111;
    localparam logic [7:0][ONLINE_W-1:0] ONLINE_PLAN =
        {6'd2, 6'd17, 6'd1, 6'd3, 6'd32, 6'd63, 6'd32, 6'd2};

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CMD_W-1:0]    command = '0;
    logic [CPU_W-1:0]    requester = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                granted;
    logic                held_by_requester;
    logic [DEPTH_W-1:0]  nest_depth;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Mirror of the lock and its configuration
    logic                sched_run = 1'b0;
    logic [ONLINE_W-1:0] online = ONLINE_RST;
    logic                lock_taken = 1'b0;
    logic [CPU_W-1:0]    lock_owner = '0;
    logic [DEPTH_W-1:0]  lock_depth = '0;
    logic                boot_waiting = 1'b0;

    // Responses predicted for accepted requests, oldest first
    res_t pending_responses[$];

    int failures = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    recursive_kernel_lock_arbiter u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .requester         (requester),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .granted           (granted),
        .held_by_requester (held_by_requester),
        .nest_depth        (nest_depth),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the mirror and return the response it should give.
    // The free-lock state always carries owner zero, so dropping the lock
    // clears all three owner fields.
    function automatic res_t predict_lock_response(input logic [CMD_W-1:0] cmd,
                                                   input logic [CPU_W-1:0] cpu_in);
        res_t             r;
        logic [CPU_W-1:0] cpu;
        logic             gate;
        r = '0;
        // Requesters past the CPU count fold onto the boot CPU
        cpu = (int'(cpu_in) >= CPUS) ? BOOT_CPU : cpu_in;
        gate = sched_run && (online >= MIN_ONLINE);
        case (cmd)
            CMD_ENTER, CMD_TRY:
            begin
                if (!gate)
                    r.granted = 1'b1;
                else if (lock_taken && lock_owner == cpu)
                begin
                    // Nest; the depth saturates rather than wrapping
                    r.granted = 1'b1;
                    if (lock_depth != DEPTH_MAX)
                        lock_depth = lock_depth + 1'b1;
                end
                else if (cmd == CMD_TRY && cpu != BOOT_CPU && boot_waiting)
                    r.granted = 1'b0;
                else if (!lock_taken)
                begin
                    r.granted = 1'b1;
                    lock_taken = 1'b1;
                    lock_owner = cpu;
                    lock_depth = DEPTH_W'(1);
                    if (cpu == BOOT_CPU)
                        boot_waiting = 1'b0;
                end
                else if (cmd == CMD_ENTER && cpu == BOOT_CPU)
                    boot_waiting = 1'b1;
            end
            CMD_REL_ONE:
            begin
                // Not gated: the owner's release of one level goes through even with the gate closed
                if (lock_taken && lock_owner == cpu && lock_depth != 0)
                begin
                    lock_depth = lock_depth - 1'b1;
                    if (lock_depth == 0)
                    begin
                        lock_taken = 1'b0;
                        lock_owner = '0;
                    end
                end
            end
            CMD_REL_ALL:
            begin
                if (gate && lock_taken && lock_owner == cpu)
                begin
                    lock_taken = 1'b0;
                    lock_owner = '0;
                    lock_depth = '0;
                end
            end
            default: ;
        endcase
        r.held = lock_taken && lock_owner == cpu && lock_depth != 0;
        r.depth = lock_depth;
        return r;
    endfunction

    function automatic void flag_error(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
        failures++;
        if (failures <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endfunction

    // Sample both channels at the falling edge, before the
    // rising edge that completes a transfer, so nothing here races the block.
    // Check the response first so a transfer on an empty store is caught
    // before this cycle's request is predicted.
    always @(negedge clk)
    begin : watch_channels
        res_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_responses.size() == 0)
                    flag_error("response with none pending", '0,
                               32'({granted, held_by_requester, nest_depth}));
                else
                begin
                    want = pending_responses.pop_front();
                    if (granted !== want.granted)
                        flag_error("granted", 32'(want.granted), 32'(granted));
                    if (held_by_requester !== want.held)
                        flag_error("held_by_requester", 32'(want.held),
                                   32'(held_by_requester));
                    if (nest_depth !== want.depth)
                        flag_error("nest_depth", 32'(want.depth), 32'(nest_depth));
                end
            end
            if (in_valid && in_ready)
                pending_responses.push_back(predict_lock_response(command, requester));
        end
    end

    // Receiver: a long hold-off wins over the random stall rate
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic apply_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 69; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            IDLE_BOTH:     begin send_idle_pct = 11; recv_stall_pct = 11; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Offer one request and return at the edge that transfers it. Valid stays
    // high into the next request unless an idle gap is drawn.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CPU_W-1:0] cpu);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        requester <= cpu;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Drop valid and hold until every predicted response has been seen,
    // then let the two-stage pipeline run on with valid low.
    task automatic settle_traffic();
        in_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register, then read it back in a second transfer with psel
    // held high between the two.
    task automatic write_register(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_SCHED)
        begin
            sched_run = value[0];
            readback = APB_DW'(sched_run);
        end
        else
        begin
            online = value[ONLINE_W-1:0];
            readback = APB_DW'(online);
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== readback)
            flag_error("register readback", readback, prdata);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic sched_val, input logic [ONLINE_W-1:0] online_val);
        settle_traffic();
        write_register(ADDR_SCHED, APB_DW'(sched_val));
        write_register(ADDR_ONLINE, APB_DW'(online_val));
    endtask

    // Out of reset the gate is closed: acquires are granted with no effect
    task automatic test_gate_closed();
        send_request(CMD_ENTER, 5'd31);
        send_request(CMD_TRY, BOOT_CPU);
        send_request(CMD_REL_ONE, BOOT_CPU);
        send_request(CMD_REL_ALL, 5'd31);
        send_request(CMD_QUERY, 5'd31);
        send_request(CMD_SPARE_LAST, BOOT_CPU);
        // Scheduler up but a single CPU online keeps the gate closed
        configure(1'b1, 6'd1);
        send_request(CMD_ENTER, 5'd10);
        send_request(CMD_QUERY, 5'd10);
    endtask

    // Take, nest, refuse a second CPU, and unwind level by level
    task automatic test_nesting();
        configure(1'b1, MIN_ONLINE);
        send_request(CMD_ENTER, BOOT_CPU);
        send_request(CMD_ENTER, BOOT_CPU);
        send_request(CMD_QUERY, BOOT_CPU);
        send_request(CMD_ENTER, 5'd31);
        send_request(CMD_REL_ONE, 5'd31);
        send_request(CMD_REL_ALL, 5'd31);
        send_request(CMD_SPARE_FIRST, BOOT_CPU);
        send_request(CMD_REL_ONE, BOOT_CPU);
        send_request(CMD_REL_ONE, BOOT_CPU);
        send_request(CMD_REL_ONE, BOOT_CPU);
    endtask

    // A boot CPU refused on a plain enter blocks timer try-requests from others until it wins
    task automatic test_boot_cpu_priority();
        send_request(CMD_ENTER, 5'd5);
        send_request(CMD_TRY, BOOT_CPU);
        send_request(CMD_TRY, 5'd7);
        send_request(CMD_ENTER, BOOT_CPU);
        send_request(CMD_TRY, 5'd7);
        send_request(CMD_TRY, 5'd5);
        send_request(CMD_REL_ALL, 5'd5);
        // Lock is free but the boot CPU still waits: other timers stay out
        send_request(CMD_TRY, 5'd9);
        send_request(CMD_ENTER, 5'd9);
        send_request(CMD_REL_ALL, 5'd9);
        send_request(CMD_TRY, BOOT_CPU);
        send_request(CMD_REL_ONE, BOOT_CPU);
        send_request(CMD_TRY, 5'd9);
        send_request(CMD_REL_ONE, 5'd9);
    endtask

    // Nest past the top of the depth counter; it must stick at the maximum
    task automatic test_depth_saturation();
        repeat (int'(DEPTH_MAX) + 3)
            send_request(CMD_ENTER, 5'd17);
        send_request(CMD_REL_ONE, 5'd17);
        send_request(CMD_ENTER, 5'd17);
        send_request(CMD_ENTER, 5'd17);
        send_request(CMD_REL_ALL, 5'd17);
    endtask

    // Close the gate with the lock held: release all is ignored, one-level
    // release still goes through
    task automatic test_gate_closed_while_held();
        send_request(CMD_ENTER, 5'd12);
        send_request(CMD_ENTER, 5'd12);
        configure(1'b0, 6'd32);
        send_request(CMD_ENTER, 5'd3);
        send_request(CMD_REL_ALL, 5'd12);
        send_request(CMD_QUERY, 5'd12);
        send_request(CMD_REL_ONE, 5'd12);
        configure(1'b1, 6'd63);
        send_request(CMD_ENTER, 5'd12);
        send_request(CMD_REL_ALL, 5'd12);
    endtask

    // Hold the receiver off long enough to fill the pipeline and stall input
    task automatic test_backpressure();
        apply_idle(IDLE_NONE);
        hold_left = 60;
        for (int n = 0; n < 24; n++)
            send_request((n % 3 == 0) ? CMD_REL_ONE : CMD_ENTER, 5'd20 + 5'(n % 2));
        settle_traffic();
    endtask

    // Random traffic from a small crowd of CPUs so that contention, nesting
    // and the boot-CPU flag all come up often; a few strangers add noise
    task automatic test_random_traffic();
        logic [CPU_W-1:0] crowd [4];
        logic [CMD_W-1:0] cmd;
        logic [CPU_W-1:0] cpu;
        int               pick;
        for (int phase = 0; phase < 8; phase++)
        begin
            configure(SCHED_PLAN[phase], ONLINE_PLAN[phase]);
            apply_idle(idle_mode_t'(phase % 4));
            crowd[0] = BOOT_CPU;
            for (int k = 1; k < 4; k++)
                crowd[k] = CPU_W'($urandom_range(31));
            for (int n = 0; n < 120; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                    cmd = CMD_ENTER;
                else if (pick < 55)
                    cmd = CMD_TRY;
                else if (pick < 75)
                    cmd = CMD_REL_ONE;
                else if (pick < 83)
                    cmd = CMD_REL_ALL;
                else if (pick < 93)
                    cmd = CMD_QUERY;
                else
                    cmd = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
                if ($urandom_range(99) < 75)
                    cpu = crowd[$urandom_range(3)];
                else
                    cpu = CPU_W'($urandom_range(31));
                send_request(cmd, cpu);
            end
        end
    endtask

    initial
    begin
        // Hold reset low from time zero, then release it on a rising edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apply_idle(IDLE_NONE);
        test_gate_closed();
        test_nesting();
        test_boot_cpu_priority();
        test_depth_saturation();
        test_gate_closed_while_held();
        test_backpressure();
        test_random_traffic();
        // Drain, then let the pipeline run dry before judging
        settle_traffic();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/rkla_pkg.sv
design/rkla_cfg_regs.sv
design/rkla_lock_core.sv
design/recursive_kernel_lock_arbiter.sv
design/rkla_checker.sv
sim/tb.sv
